// File: design/mlpbp_pkg.sv
// ---------------------------------------------------------------------------
// mlpbp_pkg
// Shared constants, codes and the sigmoid table entry function.
// ---------------------------------------------------------------------------
package mlpbp_pkg;

    localparam int HIDDEN_UNITS_DEF = 3;
    localparam int SIG_DEPTH_DEF    = 256;

    localparam int Q12_ONE = 4096;
    localparam int ACT_W   = 13;    // Q1.12 activation, 0..4096
    localparam int ACC_W   = 50;    // net sum in Q.28
    localparam int MA_W    = 40;    // shared multiplier, operand A
    localparam int MB_W    = 28;    // shared multiplier, operand B
    localparam int PROD_W  = MA_W + MB_W;

    localparam logic [11:0] LR_RESET  = 12'd3277;
    localparam logic [11:0] MOM_RESET = 12'd3072;

    localparam logic [1:0] OP_INFER = 2'd0;
    localparam logic [1:0] OP_TRAIN = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    localparam logic CFG_LR  = 1'b0;
    localparam logic CFG_MOM = 1'b1;

    // unsigned quotient by shift and subtract; elaboration only
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(4096*sigmoid(m)) at the midpoint of bin k; truncated Taylor exp.
    // Evaluated at elaboration only.
    function automatic logic [ACT_W-1:0] f_sig_entry(input int k, input int depth);
        longint          x;
        longint unsigned z;
        longint unsigned one;
        longint unsigned e;
        longint unsigned term;
        longint unsigned s;
        x    = longint'(f_udiv((2 * longint'(k) + 1) * 524288, depth)) - 524288;
        z    = (x < 0) ? longint'(-x) : longint'(x);
        one  = 64'd1 << 32;
        e    = 64'd0;
        term = one;
        for (int n = 1; n <= 80; n++) begin
            if (term != 0) begin
                e    = e + term;
                term = f_udiv((term * z) >> 16, n);
            end
        end
        s = f_udiv(e * 8192 + e + one, (e + one) * 2);
        return (x >= 0) ? ACT_W'(s) : ACT_W'(64'd4096 - s);
    endfunction

endpackage

// File: design/mlp_backprop_momentum_trainer.sv
// ---------------------------------------------------------------------------
// mlp_backprop_momentum_trainer
// 2-input, 1-output sigmoid MLP with one backprop step with momentum.
// ---------------------------------------------------------------------------
// Throughput: one item at a time; the next item is taken once the result
//   sits in the output register. Every product goes through one shared
//   multiplier and every weight read through the single memory read port.
// Reset: synchronous, active low; all weights and momentum steps read as
//   zero (per-entry valid bits), gains return to 0.8 and 0.75.
module mlp_backprop_momentum_trainer import mlpbp_pkg::*; #(
    parameter int HIDDEN_UNITS        = HIDDEN_UNITS_DEF,
    parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_opcode,
    input  logic signed [15:0]  i_sample_x0,
    input  logic signed [15:0]  i_sample_x1,
    input  logic [12:0]         i_target_value,
    input  logic [3:0]          i_weight_index,
    input  logic signed [31:0]  i_weight_value,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [12:0]         o_net_output,
    output logic signed [13:0]  o_output_error,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [11:0]         i_cfg_data
);

    localparam int H     = HIDDEN_UNITS;
    localparam int SLOTS = 4 * H + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(2 * H + 1);
    localparam int HW    = (H > 1) ? $clog2(H) : 1;
    localparam int DL_W  = 36;

    // Sequencer. Forward: per term read / multiply / accumulate, then table
    // lookup in SIG_IX and SIG_LD. Update: read, act*lr, *delta, mom*old,
    // step sum, writeback. Hidden delta: three extra multiplies.
    typedef enum logic [18:0] {
        ST_IDLE   = 19'h00001,
        ST_F_RD   = 19'h00002,
        ST_F_MUL  = 19'h00004,
        ST_F_ACC  = 19'h00008,
        ST_SIG_IX = 19'h00010,
        ST_SIG_LD = 19'h00020,
        ST_E_1    = 19'h00040,
        ST_E_2    = 19'h00080,
        ST_E_3    = 19'h00100,
        ST_U_RD   = 19'h00200,
        ST_U_M1   = 19'h00400,
        ST_U_M2   = 19'h00800,
        ST_U_M3   = 19'h01000,
        ST_U_WR   = 19'h02000,
        ST_H_PS   = 19'h04000,
        ST_H_PD   = 19'h08000,
        ST_H_M    = 19'h10000,
        ST_H_DH   = 19'h20000,
        ST_DONE   = 19'h40000
    } t_state;

    // update order: hidden-output, output bias, input-hidden, hidden biases
    typedef enum logic [3:0] {
        PH_HO = 4'b0001,
        PH_OB = 4'b0010,
        PH_IH = 4'b0100,
        PH_HB = 4'b1000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_ph;

    logic [CW-1:0] r_i;      // forward hidden unit
    logic [CW-1:0] r_j;      // forward term
    logic [CW-1:0] r_k;      // update slot within phase
    logic          r_fout;   // forward: output layer sum
    logic          r_train;
    logic          r_out_valid;
    logic [11:0]   r_lr;
    logic [11:0]   r_mom;

    logic signed [15:0]       r_x0, r_x1;
    logic [12:0]              r_tgt;
    logic [ACT_W-1:0]         r_h [H];
    logic signed [DL_W-1:0]   r_dh [H];
    logic [ACT_W-1:0]         r_y;
    logic signed [13:0]       r_err;
    logic signed [23:0]       r_dout;
    logic signed [ACC_W-1:0]  r_acc;
    logic [AW-1:0]            r_addr;
    logic signed [31:0]       r_g;
    logic signed [31:0]       r_snew;
    logic signed [31:0]       r_wnew;
    logic signed [39:0]       r_ps;
    logic [12:0]              r_out_y;
    logic signed [13:0]       r_out_err;

    logic                     c_in_acc, c_is_load, c_slot_ok, c_out_free, c_f_last;
    logic [AW-1:0]            c_fwd_addr, c_upd_addr, c_rd_addr, c_wr_addr;
    logic signed [MB_W-1:0]   c_fwd_act, c_upd_act;
    logic signed [DL_W-1:0]   c_upd_delta;
    logic signed [MA_W-1:0]   m_a;
    logic signed [MB_W-1:0]   m_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] c_sh12, c_sh16, c_sh32;
    logic signed [31:0]       c_wq, c_sq, c_wnew, c_snew, c_wr_w, c_wr_s;
    logic signed [DL_W-1:0]   c_dh;
    logic signed [13:0]       c_err;
    logic [ACT_W-1:0]         c_sig, c_hk, c_one_y, c_one_h;
    logic                     c_we;

    function automatic logic signed [31:0] f_sat32(input logic signed [33:0] v);
        if ((&v[33:31]) || !(|v[33:31])) begin
            return v[31:0];
        end
        return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // ---------------- handshakes ----------------
    assign c_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign c_is_load  = (i_opcode == OP_LOAD);
    assign c_slot_ok  = int'(i_weight_index) < SLOTS;
    assign c_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_net_output   = r_out_y;
    assign o_output_error = r_out_err;
    assign o_cfg_ready    = 1'b1;

    // ---------------- shifted product views ----------------
    assign c_sh12 = r_prod >>> 12;
    assign c_sh16 = r_prod >>> 16;
    assign c_sh32 = r_prod >>> 32;

    // hidden delta clamped to a signed 36-bit range
    assign c_dh = ((&c_sh12[PROD_W-1:DL_W-1]) || !(|c_sh12[PROD_W-1:DL_W-1]))
                ? c_sh12[DL_W-1:0]
                : (c_sh12[PROD_W-1] ? {1'b1, {(DL_W-1){1'b0}}} : {1'b0, {(DL_W-1){1'b1}}});

    // new step = gradient part + momentum part, saturated
    assign c_snew = f_sat32(34'(r_g) + 34'($signed(c_sh12[32:0])));
    assign c_wnew = f_sat32(34'(c_wq) + 34'(r_snew));

    assign c_err   = $signed({1'b0, r_tgt}) - $signed({1'b0, r_y});
    assign c_one_y = ACT_W'(Q12_ONE) - r_y;
    assign c_hk    = r_h[r_k[HW-1:0]];
    assign c_one_h = ACT_W'(Q12_ONE) - c_hk;

    // ---------------- address and operand selection ----------------
    assign c_f_last = r_fout ? (r_j == CW'(H)) : (r_j == CW'(2));

    always_comb begin
        if (r_fout) begin
            c_fwd_addr = (r_j == CW'(H)) ? AW'(4 * H) : AW'(2 * H + int'(r_j));
            c_fwd_act  = (r_j == CW'(H)) ? $signed(MB_W'(Q12_ONE))
                                         : $signed(MB_W'(r_h[r_j[HW-1:0]]));
        end else if (r_j == CW'(0)) begin
            c_fwd_addr = AW'(2 * int'(r_i));
            c_fwd_act  = MB_W'(r_x0);
        end else if (r_j == CW'(1)) begin
            c_fwd_addr = AW'(2 * int'(r_i) + 1);
            c_fwd_act  = MB_W'(r_x1);
        end else begin
            c_fwd_addr = AW'(3 * H + int'(r_i));
            c_fwd_act  = $signed(MB_W'(Q12_ONE));
        end
    end

    always_comb begin
        case (r_ph)
            PH_HO: begin
                c_upd_addr  = AW'(2 * H + int'(r_k));
                c_upd_delta = DL_W'(r_dout);
                c_upd_act   = $signed(MB_W'(c_hk));
            end
            PH_OB: begin
                c_upd_addr  = AW'(4 * H);
                c_upd_delta = DL_W'(r_dout);
                c_upd_act   = $signed(MB_W'(Q12_ONE));
            end
            PH_IH: begin
                c_upd_addr  = AW'(r_k);
                c_upd_delta = r_dh[r_k[HW:1]];
                c_upd_act   = r_k[0] ? MB_W'(r_x1) : MB_W'(r_x0);
            end
            PH_HB: begin
                c_upd_addr  = AW'(3 * H + int'(r_k));
                c_upd_delta = r_dh[r_k[HW-1:0]];
                c_upd_act   = $signed(MB_W'(Q12_ONE));
            end
            default: begin
                c_upd_addr  = '0;
                c_upd_delta = '0;
                c_upd_act   = '0;
            end
        endcase
    end

    // read address holds over a whole step so the read data stays put
    assign c_rd_addr = (r_state == ST_F_RD || r_state == ST_F_MUL || r_state == ST_F_ACC)
                     ? c_fwd_addr : c_upd_addr;

    always_comb begin
        case (r_state)
            ST_F_MUL: begin
                m_a = MA_W'(c_wq);
                m_b = c_fwd_act;
            end
            ST_E_1: begin
                m_a = MA_W'(c_err);
                m_b = $signed(MB_W'(r_y));
            end
            ST_E_2: begin
                m_a = r_prod[MA_W-1:0];
                m_b = $signed(MB_W'(c_one_y));
            end
            // act*lr first; it fits operand B, the wide delta goes on A
            ST_U_RD: begin
                m_a = MA_W'(c_upd_act);
                m_b = $signed(MB_W'(r_lr));
            end
            ST_U_M1: begin
                m_a = MA_W'(c_upd_delta);
                m_b = r_prod[MB_W-1:0];
            end
            ST_U_M2: begin
                m_a = MA_W'(c_sq);
                m_b = $signed(MB_W'(r_mom));
            end
            ST_H_PS: begin
                m_a = MA_W'(r_wnew);
                m_b = MB_W'(r_dout);
            end
            ST_H_PD: begin
                m_a = $signed(MA_W'(c_hk));
                m_b = $signed(MB_W'(c_one_h));
            end
            ST_H_M: begin
                m_a = MA_W'(r_ps);
                m_b = c_sh12[MB_W-1:0];
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // ---------------- memory write port ----------------
    // Loads write in the accept cycle; updates in U_WR. A read of the written
    // slot in that cycle returns stale data that is never used: no forwarding.
    assign c_we      = (c_in_acc && c_is_load && c_slot_ok) || (r_state == ST_U_WR);
    assign c_wr_addr = (r_state == ST_U_WR) ? r_addr : AW'(i_weight_index);
    assign c_wr_w    = (r_state == ST_U_WR) ? c_wnew : i_weight_value;
    assign c_wr_s    = (r_state == ST_U_WR) ? r_snew : 32'sd0;

    mlpbp_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (c_rd_addr),
        .i_we        (c_we),
        .i_wr_addr   (c_wr_addr),
        .i_wr_weight (c_wr_w),
        .i_wr_step   (c_wr_s),
        .o_weight    (c_wq),
        .o_step      (c_sq)
    );

    mlpbp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (m_a),
        .i_b    (m_b),
        .o_prod (r_prod)
    );

    mlpbp_sigm #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_sigm (
        .i_clk   (i_clk),
        .i_acc   (r_acc),
        .o_value (c_sig)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (c_in_acc) begin
                           n_state = c_is_load ? ST_DONE : ST_F_RD;
                       end
            ST_F_RD:   n_state = ST_F_MUL;
            ST_F_MUL:  n_state = ST_F_ACC;
            ST_F_ACC:  n_state = c_f_last ? ST_SIG_IX : ST_F_RD;
            ST_SIG_IX: n_state = ST_SIG_LD;
            ST_SIG_LD: begin
                if (!r_fout) begin
                    n_state = ST_F_RD;
                end else begin
                    n_state = r_train ? ST_E_1 : ST_DONE;
                end
            end
            ST_E_1:    n_state = ST_E_2;
            ST_E_2:    n_state = ST_E_3;
            ST_E_3:    n_state = ST_U_RD;
            ST_U_RD:   n_state = ST_U_M1;
            ST_U_M1:   n_state = ST_U_M2;
            ST_U_M2:   n_state = ST_U_M3;
            ST_U_M3:   n_state = ST_U_WR;
            ST_U_WR: begin
                if (r_ph == PH_HO) begin
                    n_state = ST_H_PS;
                end else if (r_ph == PH_HB && r_k == CW'(H - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_U_RD;
                end
            end
            ST_H_PS:   n_state = ST_H_PD;
            ST_H_PD:   n_state = ST_H_M;
            ST_H_M:    n_state = ST_H_DH;
            ST_H_DH:   n_state = ST_U_RD;
            ST_DONE:   if (c_out_free) begin
                           n_state = ST_IDLE;
                       end
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= PH_HO;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_fout      <= 1'b0;
            r_train     <= 1'b0;
            r_out_valid <= 1'b0;
            r_lr        <= LR_RESET;
            r_mom       <= MOM_RESET;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LR:  r_lr  <= i_cfg_data;
                    CFG_MOM: r_mom <= i_cfg_data;
                    default: r_lr  <= r_lr;
                endcase
            end

            if (r_state == ST_DONE && c_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    r_i     <= '0;
                    r_j     <= '0;
                    r_fout  <= 1'b0;
                    r_train <= (i_opcode == OP_TRAIN);
                end
                ST_F_ACC: if (!c_f_last) begin
                    r_j <= r_j + CW'(1);
                end
                ST_SIG_LD: begin
                    r_j <= '0;
                    if (r_i == CW'(H - 1)) begin
                        r_fout <= 1'b1;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                ST_E_3: begin
                    r_ph <= PH_HO;
                    r_k  <= '0;
                end
                ST_U_WR: begin
                    case (r_ph)
                        PH_OB: begin
                            r_ph <= PH_IH;
                            r_k  <= '0;
                        end
                        PH_IH: begin
                            if (r_k == CW'(2 * H - 1)) begin
                                r_ph <= PH_HB;
                                r_k  <= '0;
                            end else begin
                                r_k <= r_k + CW'(1);
                            end
                        end
                        PH_HB: r_k <= r_k + CW'(1);
                        default: r_k <= r_k;
                    endcase
                end
                ST_H_DH: begin
                    if (r_k == CW'(H - 1)) begin
                        r_ph <= PH_OB;
                        r_k  <= '0;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                default: r_k <= r_k;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x0  <= i_sample_x0;
                r_x1  <= i_sample_x1;
                r_tgt <= (i_target_value > 13'd4096) ? 13'd4096 : i_target_value;
                r_acc <= '0;
                r_y   <= '0;
                r_err <= '0;
            end
            ST_F_ACC:  r_acc <= r_acc + r_prod[ACC_W-1:0];
            ST_SIG_LD: begin
                r_acc <= '0;
                if (r_fout) begin
                    r_y <= c_sig;
                end else begin
                    r_h[r_i[HW-1:0]] <= c_sig;
                end
            end
            ST_E_1:  r_err  <= c_err;
            ST_E_3:  r_dout <= c_sh12[23:0];
            ST_U_RD: r_addr <= c_upd_addr;
            ST_U_M2: r_g    <= c_sh32[31:0];
            ST_U_M3: r_snew <= c_snew;
            ST_U_WR: r_wnew <= c_wnew;
            ST_H_PD: r_ps   <= c_sh16[39:0];
            ST_H_DH: r_dh[r_k[HW-1:0]] <= c_dh;
            ST_DONE: if (c_out_free) begin
                r_out_y   <= r_y;
                r_out_err <= r_err;
            end
            default: r_addr <= r_addr;
        endcase
    end

`ifndef SYNTH
    a_load_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_in_acc && c_is_load) |=> (r_state == ST_DONE))
        else $error("load item did not go straight to result");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_we |-> ((r_state == ST_U_WR) || c_in_acc))
        else $error("memory write outside load or writeback");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_y <= 13'd4096))
        else $error("network output above one");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && c_out_free) |=> (o_out_valid && (r_state == ST_IDLE)))
        else $error("finished item not presented");
`endif

endmodule

// File: design/mlpbp_mem.sv
// ---------------------------------------------------------------------------
// mlpbp_mem
// Weight and momentum-step stores, one read and one write port each.
// ---------------------------------------------------------------------------
module mlpbp_mem import mlpbp_pkg::*; #(
    parameter int SLOTS = 4 * HIDDEN_UNITS_DEF + 1,
    parameter int AW    = $clog2(4 * HIDDEN_UNITS_DEF + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic signed [31:0]   i_wr_weight,
    input  logic signed [31:0]   i_wr_step,
    output logic signed [31:0]   o_weight,
    output logic signed [31:0]   o_step
);

    logic signed [31:0] r_wmem [SLOTS];
    logic signed [31:0] r_smem [SLOTS];
    logic [SLOTS-1:0]   r_vld;
    logic signed [31:0] r_wq;
    logic signed [31:0] r_sq;
    logic               r_vq;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_wmem[i_wr_addr] <= i_wr_weight;
            r_smem[i_wr_addr] <= i_wr_step;
        end
        r_wq <= r_wmem[i_rd_addr];
        r_sq <= r_smem[i_rd_addr];
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_vq  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_vq <= r_vld[i_rd_addr];
        end
    end

    assign o_weight = r_vq ? r_wq : 32'sd0;
    assign o_step   = r_vq ? r_sq : 32'sd0;

endmodule

// File: design/mlpbp_mul.sv
// ---------------------------------------------------------------------------
// mlpbp_mul
// Shared signed multiplier with registered product.
// ---------------------------------------------------------------------------
module mlpbp_mul import mlpbp_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MA_W-1:0]   i_a,
    input  logic signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// File: design/mlpbp_sigm.sv
// ---------------------------------------------------------------------------
// mlpbp_sigm
// Sigmoid lookup: clamp Q.28 sum, registered bin index, table read.
// ---------------------------------------------------------------------------
module mlpbp_sigm import mlpbp_pkg::*; #(
    parameter int DEPTH = SIG_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic [ACT_W-1:0]        o_value
);

    localparam int TW = $clog2(DEPTH);
    localparam int DW = $clog2(DEPTH + 1);

    typedef logic [ACT_W-1:0] t_sig_tab [DEPTH];

    function automatic t_sig_tab f_build();
        t_sig_tab tab;
        for (int k = 0; k < DEPTH; k++) begin
            tab[k] = f_sig_entry(k, DEPTH);
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = f_build();

    logic              c_fit;
    logic [31:0]       c_u;
    logic [32+DW-1:0]  c_scaled;
    logic [TW-1:0]     r_idx;

    // s + 2^31 after clamping to a signed 32-bit range
    assign c_fit = (&i_acc[ACC_W-1:31]) || !(|i_acc[ACC_W-1:31]);
    assign c_u   = c_fit ? {~i_acc[31], i_acc[30:0]}
                         : (i_acc[ACC_W-1] ? 32'h0000_0000 : 32'hFFFF_FFFF);
    assign c_scaled = (32+DW)'(c_u) * (32+DW)'(DEPTH);

    always_ff @(posedge i_clk) begin
        r_idx <= c_scaled[32 +: TW];
    end

    assign o_value = SIG_TAB[r_idx];

endmodule

// File: tb/tb_mlp_backprop_momentum_trainer.sv
// ---------------------------------------------------------------------------
// tb_mlp_backprop_momentum_trainer
// Self-checking bench for the sigmoid MLP trainer. It runs a short table of
// directed items and then random weight-load / infer / train traffic, with
// random sender gaps and receiver stalls. Each result is compared with an
// in-bench fixed-point model of the network: forward pass, backprop with
// momentum, saturation and the sigmoid table. The run covers several gain
// settings.
// ---------------------------------------------------------------------------
module tb_mlp_backprop_momentum_trainer;
    import mlpbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NH         = HIDDEN_UNITS_DEF;
    localparam int LUT_DEPTH  = SIG_DEPTH_DEF;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 150;    // longer than a full train pass
    localparam int RAND_ITEMS = 510;

    // one row of the directed table
    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        logic [12:0]        tgt;
        logic [3:0]         slot;
        logic signed [31:0] wval;
        bit                 typed;   // expected result given in the row
        logic [12:0]        t_net;
        logic [13:0]        t_err;
    } item_row_t;

    typedef struct {
        logic [12:0] net;
        logic [13:0] err;
        int          tag;
    } net_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic signed [15:0] i_sample_x0;
    logic signed [15:0] i_sample_x1;
    logic [12:0]        i_target_value;
    logic [3:0]         i_weight_index;
    logic signed [31:0] i_weight_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [12:0]        o_net_output;
    logic signed [13:0] o_output_error;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [11:0]        i_cfg_data;

    mlp_backprop_momentum_trainer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_sample_x0    (i_sample_x0),
        .i_sample_x1    (i_sample_x1),
        .i_target_value (i_target_value),
        .i_weight_index (i_weight_index),
        .i_weight_value (i_weight_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_net_output   (o_net_output),
        .o_output_error (o_output_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Network mirror: weights, momentum steps, gains, sigmoid table
    // ------------------------------------------------------------------
    int          gain_lr;
    int          gain_mom;
    int          w_ih[2*NH];
    int          w_ho[NH];
    int          w_hb[NH];
    int          w_ob;
    int          m_ih[2*NH];
    int          m_ho[NH];
    int          m_hb[NH];
    int          m_ob;
    int          sig_lut[LUT_DEPTH];

    net_result_t pending_results[$];
    int          n_errors;
    int          n_items;
    int          n_trains;
    int          n_loads;
    int          n_cfg;
    int          n_checked;
    longint      cycle_cnt;

    // round(4096 * e^z / (1 + e^z)) for z >= 0 in Q.16, exp by truncated series
    function automatic int sigmoid_pos(longint unsigned z);
        longint unsigned one;
        longint unsigned e;
        longint unsigned term;
        one  = 64'd1 << 32;
        e    = 0;
        term = one;
        for (int k = 1; k <= 80; k++) begin
            if (term != 0) begin
                e    = e + term;
                term = ((term * z) >> 16) / longint'(k);
            end
        end
        return int'((64'd8192 * e + e + one) / (64'd2 * (e + one)));
    endfunction

    function automatic void build_sig_lut();
        longint mid;
        int     sp;
        for (int k = 0; k < LUT_DEPTH; k++) begin
            mid = ((2 * longint'(k) + 1) * 524288) / LUT_DEPTH - 524288;
            sp  = sigmoid_pos(mid < 0 ? -mid : mid);
            sig_lut[k] = (mid >= 0) ? sp : Q12_ONE - sp;
        end
    endfunction

    // net sum in Q.28 -> activation in Q1.12
    function automatic longint activate(longint s);
        longint half;
        half = longint'(1) << 31;
        if (s < -half) s = -half;
        if (s > half - 1) s = half - 1;
        return sig_lut[((s + half) * LUT_DEPTH) >>> 32];
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    // gradient term plus decayed previous step
    function automatic int momentum_step(longint delta, longint act, int prev);
        longint g;
        longint m;
        g = (longint'(gain_lr) * delta * act) >>> 32;
        m = (longint'(gain_mom) * longint'(prev)) >>> 12;
        return sat32(g + m);
    endfunction

    function automatic void clear_network();
        for (int i = 0; i < 2*NH; i++) begin
            w_ih[i] = 0;
            m_ih[i] = 0;
        end
        for (int i = 0; i < NH; i++) begin
            w_ho[i] = 0;
            w_hb[i] = 0;
            m_ho[i] = 0;
            m_hb[i] = 0;
        end
        w_ob     = 0;
        m_ob     = 0;
        gain_lr  = LR_RESET;
        gain_mom = MOM_RESET;
    endfunction

    // Applies one item to the mirror and returns the result it should produce.
    function automatic net_result_t run_network(item_row_t it);
        net_result_t r;
        longint      xs[2];
        longint      hact[NH];
        longint      dhid[NH];
        longint      acc;
        longint      y;
        longint      tgt;
        longint      err;
        longint      dout;
        longint      ps;
        longint      pd;
        longint      dlim;
        int          st;
        int          k;
        r.net = '0;
        r.err = '0;
        r.tag = 0;
        dlim  = longint'(1) << 35;
        if (it.op == OP_LOAD) begin
            k = it.slot;
            if (k < 2*NH) begin
                w_ih[k] = it.wval;
                m_ih[k] = 0;
            end else if (k < 3*NH) begin
                w_ho[k-2*NH] = it.wval;
                m_ho[k-2*NH] = 0;
            end else if (k < 4*NH) begin
                w_hb[k-3*NH] = it.wval;
                m_hb[k-3*NH] = 0;
            end else if (k < 4*NH + 1) begin
                w_ob = it.wval;
                m_ob = 0;
            end
            return r;
        end
        // opcode 3 falls through as a plain forward pass
        xs[0] = it.x0;
        xs[1] = it.x1;
        for (int i = 0; i < NH; i++) begin
            acc = longint'(w_hb[i]) * Q12_ONE;
            for (int j = 0; j < 2; j++)
                acc += longint'(w_ih[2*i+j]) * xs[j];
            hact[i] = activate(acc);
        end
        acc = longint'(w_ob) * Q12_ONE;
        for (int i = 0; i < NH; i++)
            acc += longint'(w_ho[i]) * hact[i];
        y   = activate(acc);
        err = 0;
        if (it.op == OP_TRAIN) begin
            tgt  = (it.tgt > Q12_ONE) ? Q12_ONE : it.tgt;
            err  = tgt - y;
            dout = (err * y * (Q12_ONE - y)) >>> 12;
            // output layer first; hidden deltas see the updated weights
            for (int i = 0; i < NH; i++) begin
                st      = momentum_step(dout, hact[i], m_ho[i]);
                m_ho[i] = st;
                w_ho[i] = sat32(longint'(w_ho[i]) + st);
                ps      = (dout * longint'(w_ho[i])) >>> 16;
                pd      = (hact[i] * (Q12_ONE - hact[i])) >>> 12;
                dhid[i] = (ps * pd) >>> 12;
                if (dhid[i] < -dlim) dhid[i] = -dlim;
                if (dhid[i] > dlim - 1) dhid[i] = dlim - 1;
            end
            m_ob = momentum_step(dout, Q12_ONE, m_ob);
            w_ob = sat32(longint'(w_ob) + m_ob);
            for (int i = 0; i < NH; i++) begin
                for (int j = 0; j < 2; j++) begin
                    st          = momentum_step(dhid[i], xs[j], m_ih[2*i+j]);
                    m_ih[2*i+j] = st;
                    w_ih[2*i+j] = sat32(longint'(w_ih[2*i+j]) + st);
                end
            end
            for (int i = 0; i < NH; i++) begin
                st      = momentum_step(dhid[i], Q12_ONE, m_hb[i]);
                m_hb[i] = st;
                w_hb[i] = sat32(longint'(w_hb[i]) + st);
            end
        end
        r.net = y[12:0];
        r.err = err[13:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int tag, longint got, longint want);
        $display("MISMATCH item %0d %s: got %0d expected %0d", tag, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        net_result_t exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, net_output", -1, o_net_output, 0);
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (o_net_output !== exp_r.net)
                    report_mismatch("net_output", exp_r.tag, o_net_output, exp_r.net);
                if (o_output_error !== exp_r.err)
                    report_mismatch("output_error", exp_r.tag,
                                    $signed(o_output_error), $signed(exp_r.err));
            end
        end
    end

    // receiver: stall density is redrawn at regular intervals, including no stalls
    int stall_pct = 0;
    always @(negedge i_clk) begin
        if (cycle_cnt % 97 == 0) begin
            case ($urandom_range(0, 4))
                0, 1: stall_pct <= 0;
                2:    stall_pct <= 25;
                3:    stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks; all are entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(item_row_t it);
        net_result_t r;
        i_in_valid     <= 1'b1;
        i_opcode       <= it.op;
        i_sample_x0    <= it.x0;
        i_sample_x1    <= it.x1;
        i_target_value <= it.tgt;
        i_weight_index <= it.slot;
        i_weight_value <= it.wval;
        do @(posedge i_clk); while (o_in_stall);
        r     = run_network(it);
        r.tag = n_items;
        if (it.typed) begin
            r.net = it.t_net;
            r.err = it.t_err;
        end
        pending_results.push_back(r);
        n_items++;
        if (it.op == OP_TRAIN) n_trains++;
        if (it.op == OP_LOAD) n_loads++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // wait until every result is back, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_gain(logic idx, logic [11:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LR) gain_lr = val;
        else gain_mom = val;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic item_row_t row(logic [1:0] op, int x0, int x1, int tgt,
                                      int slot, int wval);
        item_row_t it;
        it.op    = op;
        it.x0    = x0[15:0];
        it.x1    = x1[15:0];
        it.tgt   = tgt[12:0];
        it.slot  = slot[3:0];
        it.wval  = wval;
        it.typed = 1'b0;
        it.t_net = '0;
        it.t_err = '0;
        return it;
    endfunction

    // loads always answer zero, in range or not
    function automatic item_row_t load_row(int slot, int wval);
        item_row_t it;
        it       = row(OP_LOAD, 16'h5a5a, 16'ha5a5, 8191, slot, wval);
        it.typed = 1'b1;
        return it;
    endfunction

    function automatic int rand_weight();
        if ($urandom_range(0, 9) == 0) return int'($urandom());
        return $signed($urandom_range(0, 393216)) - 196608;   // about +-3.0
    endfunction

    function automatic int rand_sample();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535);
        return $signed($urandom_range(0, 16384)) - 8192;      // +-2.0
    endfunction

    // mostly training traffic, with loads reshaping the network
    function automatic item_row_t rand_item();
        item_row_t   it;
        int          pick;
        logic [1:0]  op;
        int          tgt;
        pick = $urandom_range(0, 99);
        if (pick < 55) op = OP_TRAIN;
        else if (pick < 70) op = OP_INFER;
        else if (pick < 75) op = 2'd3;
        else op = OP_LOAD;
        tgt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                          : $urandom_range(0, Q12_ONE);
        it = row(op, rand_sample(), rand_sample(), tgt,
                 $urandom_range(0, 15), rand_weight());
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        item_row_t directed[$];
        logic [11:0] lr_set[5];
        logic [11:0] mom_set[5];
        int          burst;
        int          per_phase;
        bit          held;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_INFER;
        i_sample_x0    = '0;
        i_sample_x1    = '0;
        i_target_value = '0;
        i_weight_index = '0;
        i_weight_value = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_LR;
        i_cfg_data     = '0;
        n_errors = 0; n_items = 0; n_trains = 0; n_loads = 0;
        n_cfg = 0; n_checked = 0; cycle_cnt = 0;
        held = 1'b0;
        clear_network();
        build_sig_lut();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: all-zero network, extreme weights, bad slots, opcode 3,
        // target above one, extreme samples
        directed.push_back(row(OP_INFER, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_TRAIN, 0, 0, Q12_ONE, 0, 0));
        directed.push_back(load_row(0, 32'h7fffffff));
        directed.push_back(load_row(1, 32'h80000000));
        directed.push_back(load_row(6, 32'h00010000));
        directed.push_back(load_row(12, 32'h7fffffff));
        directed.push_back(row(OP_INFER, 32767, -32768, 0, 0, 0));
        directed.push_back(load_row(13, 123));
        directed.push_back(load_row(15, -1));
        directed.push_back(row(2'd3, 4096, -4096, 100, 7, 55));
        directed.push_back(row(OP_TRAIN, 4096, 4096, 8191, 0, 0));
        directed.push_back(row(OP_TRAIN, 32767, 32767, 0, 0, 0));
        directed.push_back(load_row(12, 32'h80000000));
        directed.push_back(row(OP_TRAIN, -32768, -32768, Q12_ONE, 0, 0));
        directed.push_back(load_row(9, 32'h00020000));
        directed.push_back(load_row(3, -196608));
        directed.push_back(load_row(7, 32'h7fffffff));
        directed.push_back(load_row(11, -65536));
        directed.push_back(row(OP_TRAIN, 4096, 0, 2048, 0, 0));
        directed.push_back(row(OP_TRAIN, -4096, 8192, 4097, 0, 0));
        directed.push_back(row(OP_INFER, -1, 1, 0, 0, 0));
        directed.push_back(row(OP_TRAIN, 0, -4096, 1, 0, 0));
        foreach (directed[i]) send_item(directed[i]);
        drain_results();

        // gain settings: both extremes, mixed, reset values again
        lr_set  = '{12'd4095, 12'd0,    12'd4095, 12'd1024, LR_RESET};
        mom_set = '{12'd4095, 12'd4095, 12'd0,    12'd2048, MOM_RESET};
        per_phase = RAND_ITEMS / 5;

        for (int ph = 0; ph < 5; ph++) begin
            write_gain(CFG_LR, lr_set[ph]);
            write_gain(CFG_MOM, mom_set[ph]);
            // fresh random network: load every slot
            for (int s = 0; s < 4*NH + 1; s++)
                send_item(row(OP_LOAD, 0, 0, 0, s, rand_weight()));
            for (int n = 0; n < per_phase; ) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < per_phase; b++, n++)
                    send_item(rand_item());
                if (ph == 1 && !held && n >= per_phase / 2) begin
                    // hold off until the block has answered everything
                    held = 1'b1;
                    i_in_valid <= 1'b0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end else if ($urandom_range(0, 2) != 0) begin
                    idle_cycles($urandom_range(1, 40));
                end
            end
            drain_results();
        end

        if (pending_results.size() != 0)
            report_mismatch("results never returned", -1, 0, pending_results.size());

        $display("Ran %0d items (%0d train, %0d load), %0d results checked, %0d gain writes",
                 n_items, n_trains, n_loads, n_checked, n_cfg);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
design/mlpbp_pkg.sv
design/mlpbp_mem.sv
design/mlpbp_mul.sv
design/mlpbp_sigm.sv
design/mlp_backprop_momentum_trainer.sv
tb/tb_mlp_backprop_momentum_trainer.sv
